/* hw/rtl/tlc_pkg.sv */
package tlc_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int WORD_BYTES  = 4;
	localparam int L1_BYTES    = 256;
	localparam int L2_BYTES    = 512;
	localparam int MEM_BYTES   = 65536;

	localparam int OP_W      = 2;
	localparam int ADDR_W    = 32;
	localparam int WORD_W    = 8 * WORD_BYTES;
	localparam int TIME_W    = 32;
	localparam int COST_W    = 16;
	localparam int CFG_IDX_W = 3;

	localparam int BLK_WORDS = BLOCK_BYTES / WORD_BYTES;
	localparam int WIDX_W    = (BLK_WORDS > 1) ? $clog2(BLK_WORDS) : 1;
	localparam int WOFF      = $clog2(WORD_BYTES);
	localparam int BOFF      = $clog2(BLOCK_BYTES);
	localparam int MEM_BLKS  = MEM_BYTES / BLOCK_BYTES;
	localparam int BA_W      = $clog2(MEM_BLKS);
	localparam int L1_SETS   = L1_BYTES / BLOCK_BYTES;
	localparam int L1_SW     = $clog2(L1_SETS);
	localparam int L1_TW     = BA_W - L1_SW;
	localparam int L2_SETS   = L2_BYTES / BLOCK_BYTES / 2;
	localparam int L2_SW     = $clog2(L2_SETS);
	localparam int L2_TW     = BA_W - L2_SW;
	localparam int L2_LINES  = 2 * L2_SETS;

	localparam int Q_DEPTH = 2;
	localparam int QA_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_L1_RD  = 3'd0,
		REG_L1_WR  = 3'd1,
		REG_L2_RD  = 3'd2,
		REG_L2_WR  = 3'd3,
		REG_MEM_RD = 3'd4,
		REG_MEM_WR = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		K_READ,
		K_WRITE,
		K_CLEAR,
		K_NOP,
		K_ERR
	} kind_t;

	typedef logic [BLK_WORDS-1:0][WORD_W-1:0] blk_t;

	typedef struct packed {
		kind_t              kind;
		logic [BA_W-1:0]    blk;
		logic [WIDX_W-1:0]  widx;
		logic [WORD_W-1:0]  wdata;
	} req_t;

	typedef struct packed {
		logic [COST_W-1:0] l1_rd;
		logic [COST_W-1:0] l1_wr;
		logic [COST_W-1:0] l2_rd;
		logic [COST_W-1:0] l2_wr;
		logic [COST_W-1:0] mem_rd;
		logic [COST_W-1:0] mem_wr;
	} costs_t;

	typedef struct packed {
		logic valid;
		req_t head;
	} q_stat_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_ctl_t;

endpackage

/* hw/rtl/tlc_req_if.sv */
interface tlc_req_if;
	logic                         valid;
	logic                         ready;
	logic [tlc_pkg::OP_W-1:0]     opcode;
	logic [tlc_pkg::ADDR_W-1:0]   address;
	logic [tlc_pkg::WORD_W-1:0]   write_data;

	modport source (output valid, output opcode, output address, output write_data,
		input ready);
	modport sink (input valid, input opcode, input address, input write_data,
		output ready);
endinterface

/* hw/rtl/tlc_rsp_if.sv */
interface tlc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [tlc_pkg::WORD_W-1:0]   read_data;
	logic [tlc_pkg::TIME_W-1:0]   total_time;
	logic                         out_of_range;

	modport source (output valid, output read_data, output total_time, output out_of_range,
		input ready);
	modport sink (input valid, input read_data, input total_time, input out_of_range,
		output ready);
endinterface

/* hw/rtl/tlc_front.sv */
module tlc_front (
	input  logic              clk,
	input  logic              arst_n,
	tlc_req_if.sink           req,
	input  tlc_pkg::bk_ctl_t  ctl,
	output tlc_pkg::q_stat_t  qs
);

	tlc_pkg::req_t cls;
	tlc_pkg::req_t fifo_q [tlc_pkg::Q_DEPTH];
	logic [tlc_pkg::QA_W-1:0] wr_ptr_q;
	logic [tlc_pkg::QA_W-1:0] rd_ptr_q;
	logic [tlc_pkg::QC_W-1:0] cnt_q;
	logic oor;
	logic push;

	assign oor = ({1'b0, req.address} >
		(tlc_pkg::ADDR_W + 1)'(tlc_pkg::MEM_BYTES - tlc_pkg::WORD_BYTES));

	always_comb begin
		cls.blk   = tlc_pkg::BA_W'(req.address >> tlc_pkg::BOFF);
		cls.widx  = tlc_pkg::WIDX_W'((req.address >> tlc_pkg::WOFF) &
			tlc_pkg::ADDR_W'(tlc_pkg::BLK_WORDS - 1));
		cls.wdata = req.write_data;
		case (req.opcode)
			tlc_pkg::OP_READ:  cls.kind = oor ? tlc_pkg::K_ERR : tlc_pkg::K_READ;
			tlc_pkg::OP_WRITE: cls.kind = oor ? tlc_pkg::K_ERR : tlc_pkg::K_WRITE;
			tlc_pkg::OP_CLEAR: cls.kind = tlc_pkg::K_CLEAR;
			default:           cls.kind = tlc_pkg::K_NOP;
		endcase
	end

	assign req.ready = (cnt_q != tlc_pkg::QC_W'(tlc_pkg::Q_DEPTH)) && !ctl.clearing;
	assign push      = req.valid && req.ready;
	assign qs.valid  = (cnt_q != '0);
	assign qs.head   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (ctl.pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !ctl.pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && ctl.pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= cls;
	end

endmodule

/* hw/rtl/tlc_back.sv */
module tlc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tlc_pkg::q_stat_t  qs,
	output tlc_pkg::bk_ctl_t  ctl,
	input  tlc_pkg::costs_t   costs,
	tlc_rsp_if.source         rsp
);

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_LOOK,
		S_L2LOOK,
		S_L2MRD,
		S_L2DO,
		S_INSTALL,
		S_ACCESS,
		S_RESP
	} state_t;

	state_t state_q;
	tlc_pkg::req_t req_q;
	logic [tlc_pkg::BA_W-1:0] clr_idx_q;

	logic                      l1_valid_q [tlc_pkg::L1_SETS];
	logic                      l1_dirty_q [tlc_pkg::L1_SETS];
	logic [tlc_pkg::L1_TW-1:0] l1_tag_q   [tlc_pkg::L1_SETS];
	tlc_pkg::blk_t             l1_data_q  [tlc_pkg::L1_SETS];

	logic                      l2_valid_q [tlc_pkg::L2_LINES];
	logic                      l2_dirty_q [tlc_pkg::L2_LINES];
	logic [tlc_pkg::L2_TW-1:0] l2_tag_q   [tlc_pkg::L2_LINES];
	tlc_pkg::blk_t             l2_data_q  [tlc_pkg::L2_LINES];
	logic                      lru_q      [tlc_pkg::L2_SETS];

	tlc_pkg::blk_t mem [tlc_pkg::MEM_BLKS];
	tlc_pkg::blk_t mem_rd_q;

	logic [tlc_pkg::BA_W-1:0]  l2_blk_q;
	logic                      l2_wr_q;
	logic                      wb_phase_q;
	logic [tlc_pkg::L2_SW:0]   l2_ln_q;
	tlc_pkg::blk_t             l2_buf_q;
	tlc_pkg::blk_t             fresh_q;
	logic [tlc_pkg::WORD_W-1:0] rd_q;
	logic [tlc_pkg::TIME_W-1:0] time_q;

	logic                       out_valid_q;
	logic [tlc_pkg::WORD_W-1:0] out_rd_q;
	logic [tlc_pkg::TIME_W-1:0] out_time_q;
	logic                       out_err_q;

	logic [tlc_pkg::L1_SW-1:0] l1_set;
	logic [tlc_pkg::L1_TW-1:0] l1_tag;
	logic                      l1_hit;
	logic                      l1_wb;
	logic [tlc_pkg::L2_SW-1:0] l2_set;
	logic [tlc_pkg::L2_TW-1:0] l2_tag;
	logic [tlc_pkg::L2_SW:0]   ln0;
	logic [tlc_pkg::L2_SW:0]   ln1;
	logic                      hit0;
	logic                      hit1;
	logic                      victim_dirty;
	logic [tlc_pkg::COST_W-1:0] add_cost;
	logic                      out_free;

	logic                      mem_we;
	logic [tlc_pkg::BA_W-1:0]  mem_wa;
	tlc_pkg::blk_t             mem_wd;
	logic                      mem_re;

	assign l1_set = req_q.blk[tlc_pkg::L1_SW-1:0];
	assign l1_tag = req_q.blk[tlc_pkg::BA_W-1:tlc_pkg::L1_SW];
	assign l1_hit = l1_valid_q[l1_set] && (l1_tag_q[l1_set] == l1_tag);
	assign l1_wb  = l1_valid_q[l1_set] && l1_dirty_q[l1_set];

	assign l2_set = l2_blk_q[tlc_pkg::L2_SW-1:0];
	assign l2_tag = l2_blk_q[tlc_pkg::BA_W-1:tlc_pkg::L2_SW];
	assign ln0    = {l2_set, 1'b0};
	assign ln1    = {l2_set, 1'b1};
	assign hit0   = l2_valid_q[ln0] && (l2_tag_q[ln0] == l2_tag);
	assign hit1   = l2_valid_q[ln1] && (l2_tag_q[ln1] == l2_tag);
	assign victim_dirty = l2_valid_q[l2_ln_q] && l2_dirty_q[l2_ln_q];

	assign out_free     = !out_valid_q || rsp.ready;
	assign ctl.pop      = (state_q == S_IDLE) && qs.valid;
	assign ctl.clearing = (state_q == S_CLR);

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = out_rd_q;
	assign rsp.total_time   = out_time_q;
	assign rsp.out_of_range = out_err_q;

	// Each state charges at most one cost to the running total.
	always_comb begin
		case (state_q)
			S_L2LOOK: add_cost = (!hit0 && !hit1) ? costs.mem_rd : '0;
			S_L2MRD:  add_cost = victim_dirty ? costs.mem_wr : '0;
			S_L2DO:   add_cost = l2_wr_q ? costs.l2_wr : costs.l2_rd;
			S_ACCESS: add_cost = (req_q.kind == tlc_pkg::K_WRITE) ? costs.l1_wr : costs.l1_rd;
			default:  add_cost = '0;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_idx_q;
		mem_wd = '0;
		mem_re = 1'b0;
		case (state_q)
			S_CLR: mem_we = 1'b1;
			S_L2LOOK: mem_re = !hit0 && !hit1;
			S_L2MRD: begin
				mem_we = victim_dirty;
				mem_wa = {l2_tag_q[l2_ln_q], l2_set};
				mem_wd = l2_data_q[l2_ln_q];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			mem_rd_q <= mem[l2_blk_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_idx_q   <= '0;
			time_q      <= '0;
			out_valid_q <= 1'b0;
			l2_wr_q     <= 1'b0;
			wb_phase_q  <= 1'b0;
			for (int i = 0; i < tlc_pkg::L1_SETS; i++) begin
				l1_valid_q[i] <= 1'b0;
				l1_dirty_q[i] <= 1'b0;
			end
			for (int i = 0; i < tlc_pkg::L2_LINES; i++) begin
				l2_valid_q[i] <= 1'b0;
				l2_dirty_q[i] <= 1'b0;
			end
			for (int i = 0; i < tlc_pkg::L2_SETS; i++)
				lru_q[i] <= 1'b1;
		end else begin
			if (state_q == S_IDLE && qs.valid && qs.head.kind == tlc_pkg::K_CLEAR)
				time_q <= '0;
			else
				time_q <= time_q + tlc_pkg::TIME_W'(add_cost);
			if (state_q == S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (qs.valid) begin
						case (qs.head.kind)
							tlc_pkg::K_READ, tlc_pkg::K_WRITE: state_q <= S_LOOK;
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_LOOK: begin
					if (l1_hit) begin
						state_q <= S_ACCESS;
					end else begin
						l2_wr_q    <= 1'b0;
						wb_phase_q <= 1'b0;
						state_q    <= S_L2LOOK;
					end
				end
				S_L2LOOK: begin
					if (hit0 || hit1)
						state_q <= S_L2DO;
					else
						state_q <= S_L2MRD;
				end
				S_L2MRD: begin
					l2_valid_q[l2_ln_q] <= 1'b1;
					l2_dirty_q[l2_ln_q] <= 1'b0;
					state_q <= S_L2DO;
				end
				S_L2DO: begin
					if (l2_wr_q)
						l2_dirty_q[l2_ln_q] <= 1'b1;
					lru_q[l2_set] <= l2_ln_q[0];
					// After the fill read, a dirty L1 victim goes down as a block write.
					if (!wb_phase_q && l1_wb) begin
						l2_wr_q    <= 1'b1;
						wb_phase_q <= 1'b1;
						state_q    <= S_L2LOOK;
					end else begin
						state_q <= S_INSTALL;
					end
				end
				S_INSTALL: begin
					l1_valid_q[l1_set] <= 1'b1;
					l1_dirty_q[l1_set] <= 1'b0;
					state_q <= S_ACCESS;
				end
				S_ACCESS: begin
					if (req_q.kind == tlc_pkg::K_WRITE)
						l1_dirty_q[l1_set] <= 1'b1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (qs.valid)
					req_q <= qs.head;
			end
			S_LOOK: l2_blk_q <= req_q.blk;
			S_L2LOOK: begin
				if (hit0)
					l2_ln_q <= ln0;
				else if (hit1)
					l2_ln_q <= ln1;
				else
					l2_ln_q <= {l2_set, !lru_q[l2_set]};
			end
			S_L2MRD: begin
				l2_data_q[l2_ln_q] <= mem_rd_q;
				l2_tag_q[l2_ln_q]  <= l2_tag;
			end
			S_L2DO: begin
				if (l2_wr_q)
					l2_data_q[l2_ln_q] <= l2_buf_q;
				else
					fresh_q <= l2_data_q[l2_ln_q];
				if (!wb_phase_q && l1_wb) begin
					l2_blk_q <= {l1_tag_q[l1_set], l1_set};
					l2_buf_q <= l1_data_q[l1_set];
				end
			end
			S_INSTALL: begin
				l1_data_q[l1_set] <= fresh_q;
				l1_tag_q[l1_set]  <= l1_tag;
			end
			S_ACCESS: begin
				if (req_q.kind == tlc_pkg::K_WRITE)
					l1_data_q[l1_set][req_q.widx] <= req_q.wdata;
				rd_q <= l1_data_q[l1_set][req_q.widx];
			end
			S_RESP: begin
				if (out_free) begin
					out_rd_q   <= (req_q.kind == tlc_pkg::K_READ) ? rd_q : '0;
					out_time_q <= time_q;
					out_err_q  <= (req_q.kind == tlc_pkg::K_ERR);
				end
			end
			default: ;
		endcase
	end

	a_l2_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_L2LOOK) |-> !(hit0 && hit1))
		else $error("both L2 ways hit the same block");

	a_l2_fill_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_L2MRD) |=> (l2_valid_q[l2_ln_q] && !l2_dirty_q[l2_ln_q]))
		else $error("L2 fill did not leave a clean valid line");

	a_l1_install_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INSTALL) |=> (l1_hit && !l1_dirty_q[l1_set]))
		else $error("L1 install did not produce a clean hit");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && qs.valid && qs.head.kind == tlc_pkg::K_CLEAR)
		|=> (time_q == '0))
		else $error("time total not zero after a clear");

endmodule

/* hw/rtl/two_level_cache_hierarchy_core.sv */
// Write-back, write-allocate two-level cache (direct-mapped L1, 2-way LRU L2)
// in front of a 64 KiB backing memory, with a running access-time total built
// from the six cost registers. After reset the backing memory is zeroed by a
// sweep over all 4096 blocks, one block per cycle, during which no request is taken.
// Requests wait in a two-entry queue; the back-end sequencer serves one at a time.
// An L1 hit passes through lookup, access and response; a clear, an ignored or an
// out-of-range request goes straight to the response. An L1 miss adds an L2 lookup,
// a memory read on an L2 miss and an L1 install; a dirty L1 victim adds an L2 write.
module two_level_cache_hierarchy_core (
	input  logic                             clk,
	input  logic                             arst_n,
	tlc_req_if.sink                          req,
	tlc_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [tlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tlc_pkg::COST_W-1:0]       cfg_data
);

	tlc_pkg::costs_t  costs_q;
	tlc_pkg::q_stat_t qs;
	tlc_pkg::bk_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			costs_q.l1_rd  <= tlc_pkg::COST_W'(1);
			costs_q.l1_wr  <= tlc_pkg::COST_W'(1);
			costs_q.l2_rd  <= tlc_pkg::COST_W'(10);
			costs_q.l2_wr  <= tlc_pkg::COST_W'(10);
			costs_q.mem_rd <= tlc_pkg::COST_W'(100);
			costs_q.mem_wr <= tlc_pkg::COST_W'(100);
		end else if (cfg_we) begin
			case (tlc_pkg::reg_idx_t'(cfg_index))
				tlc_pkg::REG_L1_RD:  costs_q.l1_rd  <= cfg_data;
				tlc_pkg::REG_L1_WR:  costs_q.l1_wr  <= cfg_data;
				tlc_pkg::REG_L2_RD:  costs_q.l2_rd  <= cfg_data;
				tlc_pkg::REG_L2_WR:  costs_q.l2_wr  <= cfg_data;
				tlc_pkg::REG_MEM_RD: costs_q.mem_rd <= cfg_data;
				tlc_pkg::REG_MEM_WR: costs_q.mem_wr <= cfg_data;
				default: ;
			endcase
		end
	end

	tlc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.qs     (qs)
	);

	tlc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qs     (qs),
		.ctl    (ctl),
		.costs  (costs_q),
		.rsp    (rsp)
	);

endmodule
